/* design/tlfs_pkg.sv */
// ----------------------------------------------------------------------------
// tlfs_pkg
// Shared codes and control structs for the three-level feedback scheduler.
// ----------------------------------------------------------------------------
package tlfs_pkg;

  // request codes
  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  // queue level codes, 0 is highest priority
  localparam int unsigned LvlW = 2;
  localparam logic [LvlW-1:0] LVL0 = 2'd0;
  localparam logic [LvlW-1:0] LVL1 = 2'd1;
  localparam logic [LvlW-1:0] LVL2 = 2'd2;

  // configuration register map
  localparam int unsigned CfgW    = 10;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_QUANTUM0 = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_QUANTUM1 = 1'd1;

  localparam logic [CfgW-1:0] QUANTUM0_RESET = 10'd2;
  localparam logic [CfgW-1:0] QUANTUM1_RESET = 10'd4;

  // queue control from the scheduler, at most one action per queue per transaction
  typedef struct packed {
    logic push;
    logic pop;
    logic upd;
  } q_ctrl_t;

  // queue status back to the scheduler
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

/* design/tlfs_req_if.sv */
// ----------------------------------------------------------------------------
// tlfs_req_if
// Request channel: job arrival or time tick, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tlfs_req_if #(
  parameter int JOB_ID_BITS = 4,
  parameter int TIME_BITS   = 10
);
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [JOB_ID_BITS-1:0] job_id;
  logic [TIME_BITS-1:0]   burst_len;

  modport source (output valid, req_type, job_id, burst_len, input ready);
  modport sink   (input valid, req_type, job_id, burst_len, output ready);
endinterface

/* design/tlfs_res_if.sv */
// ----------------------------------------------------------------------------
// tlfs_res_if
// Result channel: one result per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tlfs_res_if #(
  parameter int JOB_ID_BITS = 4
);
  logic                   valid;
  logic                   ready;
  logic                   run_valid;
  logic [JOB_ID_BITS-1:0] run_id;
  logic [1:0]             run_level;
  logic                   finished;
  logic                   demoted;
  logic                   arrival_dropped;

  modport source (output valid, run_valid, run_id, run_level, finished, demoted,
                  arrival_dropped, input ready);
  modport sink   (input valid, run_valid, run_id, run_level, finished, demoted,
                  arrival_dropped, output ready);
endinterface

/* design/tlfs_queue.sv */
// ----------------------------------------------------------------------------
// tlfs_queue
// Circular job queue with head read, tail push, head pop and head rewrite.
// ----------------------------------------------------------------------------
module tlfs_queue
  import tlfs_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int WIDTH = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  q_ctrl_t          ctrl_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic [WIDTH-1:0] head_data_o,
  output q_stat_t          stat_o
);

  localparam int IdxW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [IdxW-1:0]  head_q, head_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW:0]    tail_sum;
  logic [CntW:0]    tail_wrap;
  logic [IdxW-1:0]  tail_idx;

  assign head_data_o  = mem_q[head_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(DEPTH));

  // head plus count stays below twice the depth while not full
  assign tail_sum  = (CntW+1)'(head_q) + (CntW+1)'(count_q);
  assign tail_wrap = (tail_sum >= (CntW+1)'(DEPTH)) ? tail_sum - (CntW+1)'(DEPTH)
                                                    : tail_sum;
  assign tail_idx  = tail_wrap[IdxW-1:0];

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (ctrl_i.pop) begin
      head_d = (head_q == IdxW'(DEPTH - 1)) ? '0 : head_q + IdxW'(1);
    end
    if (ctrl_i.push && !ctrl_i.pop) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl_i.pop && !ctrl_i.push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[tail_idx] <= wr_data_i;
    end else if (ctrl_i.upd) begin
      mem_q[head_q] <= wr_data_i;
    end
  end

endmodule

/* design/three_level_feedback_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// three_level_feedback_scheduler_unit
// Three-level strict-priority feedback scheduler: arrivals join level 0,
// ticks run the head job of the highest non-empty level and demote on
// quantum expiry when the next level has room.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+-------------------------------------
//   req      | in  | valid/ready      | req_type, job_id, burst_len
//   res      | out | valid/ready      | run_valid, run_id, run_level,
//            |     |                  | finished, demoted, arrival_dropped
//   cfg      | in  | write enable     | cfg_idx_i, cfg_data_i
//
// one transaction per cycle while each result is taken; a request passes
// through the input register, the single-pass queue head update and the
// result register
// reset empties all three queues and loads quanta 2 and 4; no clearing pass
// a stalled result holds the result register, and the input register then
// holds its transaction until the result is taken
// ----------------------------------------------------------------------------
module three_level_feedback_scheduler_unit
  import tlfs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int JOB_ID_BITS = 4,
  parameter int TIME_BITS   = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  tlfs_req_if.sink           req,
  tlfs_res_if.source         res
);

  localparam int W01 = JOB_ID_BITS + 2 * TIME_BITS;
  localparam int W2  = JOB_ID_BITS + TIME_BITS;

  // configuration
  logic [CfgW-1:0]      quant0_q, quant1_q;
  logic [TIME_BITS-1:0] qt0, qt1;

  // input register
  logic                   in_vld_q;
  logic                   in_type_q;
  logic [JOB_ID_BITS-1:0] in_id_q;
  logic [TIME_BITS-1:0]   in_burst_q;

  // result register
  logic                   out_vld_q;
  logic                   run_valid_q, run_valid_d;
  logic [JOB_ID_BITS-1:0] run_id_q, run_id_d;
  logic [LvlW-1:0]        run_level_q, run_level_d;
  logic                   finished_q, finished_d;
  logic                   demoted_q, demoted_d;
  logic                   dropped_q, dropped_d;

  logic advance;

  // queues
  q_ctrl_t          c0, c1, c2;
  q_stat_t          s0, s1, s2;
  logic [W01-1:0]   d0, d1, hd0, hd1;
  logic [W2-1:0]    d2, hd2;

  logic                   run;
  logic [LvlW-1:0]        sel_lvl;
  logic [JOB_ID_BITS-1:0] h_id;
  logic [TIME_BITS-1:0]   h_burst, h_quant, burst_dec, arr_burst;
  logic                   fin, expire;

  assign qt0 = TIME_BITS'(quant0_q);
  assign qt1 = TIME_BITS'(quant1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quant0_q <= QUANTUM0_RESET;
      quant1_q <= QUANTUM1_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_QUANTUM0: quant0_q <= cfg_data_i;
        CFG_QUANTUM1: quant1_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance   = in_vld_q && (!out_vld_q || res.ready);
  assign req.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req.ready) begin
      in_vld_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.ready && req.valid) begin
      in_type_q  <= req.req_type;
      in_id_q    <= req.job_id;
      in_burst_q <= req.burst_len;
    end
  end

  tlfs_queue #(.DEPTH(QUEUE_DEPTH), .WIDTH(W01)) u_queue0 (
    .clk_i, .rst_ni, .ctrl_i(c0), .wr_data_i(d0), .head_data_o(hd0), .stat_o(s0)
  );
  tlfs_queue #(.DEPTH(QUEUE_DEPTH), .WIDTH(W01)) u_queue1 (
    .clk_i, .rst_ni, .ctrl_i(c1), .wr_data_i(d1), .head_data_o(hd1), .stat_o(s1)
  );
  tlfs_queue #(.DEPTH(QUEUE_DEPTH), .WIDTH(W2)) u_queue2 (
    .clk_i, .rst_ni, .ctrl_i(c2), .wr_data_i(d2), .head_data_o(hd2), .stat_o(s2)
  );

  // strict priority pick
  assign run     = !(s0.empty && s1.empty && s2.empty);
  assign sel_lvl = !s0.empty ? LVL0 : (!s1.empty ? LVL1 : LVL2);

  always_comb begin
    h_quant = '0;
    unique case (sel_lvl)
      LVL0:    {h_id, h_burst, h_quant} = hd0;
      LVL1:    {h_id, h_burst, h_quant} = hd1;
      default: {h_id, h_burst} = hd2;
    endcase
  end

  assign fin       = (h_burst <= TIME_BITS'(1));
  assign expire    = (h_quant <= TIME_BITS'(1));
  assign burst_dec = h_burst - TIME_BITS'(1);
  assign arr_burst = (in_burst_q == '0) ? TIME_BITS'(1) : in_burst_q;

  always_comb begin
    c0 = '0;
    c1 = '0;
    c2 = '0;
    d0 = {in_id_q, arr_burst, qt0};
    d1 = {h_id, burst_dec, qt1};
    d2 = {h_id, burst_dec};
    run_valid_d = 1'b0;
    run_id_d    = '0;
    run_level_d = LVL0;
    finished_d  = 1'b0;
    demoted_d   = 1'b0;
    dropped_d   = 1'b0;
    if (advance) begin
      if (in_type_q == REQ_ARRIVAL) begin
        if (s0.full) begin
          dropped_d = 1'b1;
        end else begin
          c0.push = 1'b1;
        end
      end else if (run) begin
        run_valid_d = 1'b1;
        run_id_d    = h_id;
        run_level_d = sel_lvl;
        finished_d  = fin;
        unique case (sel_lvl)
          LVL0: begin
            if (fin) begin
              c0.pop = 1'b1;
            end else if (expire && !s1.full) begin
              c1.push   = 1'b1;
              c0.pop    = 1'b1;
              demoted_d = 1'b1;
            end else if (expire) begin
              // next level full, stay and reload own quantum
              c0.upd = 1'b1;
              d0     = {h_id, burst_dec, qt0};
            end else begin
              c0.upd = 1'b1;
              d0     = {h_id, burst_dec, h_quant - TIME_BITS'(1)};
            end
          end
          LVL1: begin
            if (fin) begin
              c1.pop = 1'b1;
            end else if (expire && !s2.full) begin
              c2.push   = 1'b1;
              c1.pop    = 1'b1;
              demoted_d = 1'b1;
            end else if (expire) begin
              c1.upd = 1'b1;
            end else begin
              c1.upd = 1'b1;
              d1     = {h_id, burst_dec, h_quant - TIME_BITS'(1)};
            end
          end
          default: begin
            if (fin) begin
              c2.pop = 1'b1;
            end else begin
              c2.upd = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (res.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      run_valid_q <= run_valid_d;
      run_id_q    <= run_id_d;
      run_level_q <= run_level_d;
      finished_q  <= finished_d;
      demoted_q   <= demoted_d;
      dropped_q   <= dropped_d;
    end
  end

  assign res.valid           = out_vld_q;
  assign res.run_valid       = run_valid_q;
  assign res.run_id          = run_id_q;
  assign res.run_level       = run_level_q;
  assign res.finished        = finished_q;
  assign res.demoted         = demoted_q;
  assign res.arrival_dropped = dropped_q;

endmodule

/* test/three_level_feedback_scheduler_unit_tb.sv */
// ----------------------------------------------------------------------------
// three_level_feedback_scheduler_unit_tb
// Drives arrivals and ticks into the scheduler through its request channel and
// checks every result against a cycle-free model of the three queues or, for
// fixed rows, a hand-written value. A short table of hand-picked requests
// comes first. Random phases follow, each with its own quantum setting,
// arrival mix and burst profile. Both sides of the handshake idle at random.
// ----------------------------------------------------------------------------
module three_level_feedback_scheduler_unit_tb;
  import tlfs_pkg::*;

  localparam int QDepth = 16;
  localparam int IdW    = 4;
  localparam int TimeW  = 10;
  localparam int NPhase = 7;
  localparam int PhaseItems = 130;

  typedef struct packed {
    logic             req_type;
    logic [IdW-1:0]   job_id;
    logic [TimeW-1:0] burst_len;
  } sched_req_t;

  typedef struct packed {
    logic            run_valid;
    logic [IdW-1:0]  run_id;
    logic [LvlW-1:0] run_level;
    logic            finished;
    logic            demoted;
    logic            arrival_dropped;
  } sched_res_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] burst;
    logic [TimeW-1:0] quant;
  } job_slot_t;

  typedef struct {
    sched_req_t stim;
    bit         fixed;
    sched_res_t want;
  } dir_row_t;

  localparam sched_res_t NO_RUN = '0;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic             cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]  cfg_data_i;

  tlfs_req_if #(.JOB_ID_BITS(IdW), .TIME_BITS(TimeW)) req_ch ();
  tlfs_res_if #(.JOB_ID_BITS(IdW)) res_ch ();

  three_level_feedback_scheduler_unit #(
    .QUEUE_DEPTH(QDepth),
    .JOB_ID_BITS(IdW),
    .TIME_BITS  (TimeW)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req       (req_ch),
    .res       (res_ch)
  );

  always #1 clk_i = ~clk_i;

  // scheduler model state
  job_slot_t       lvl_store[3][QDepth];
  int unsigned     lvl_head[3];
  int unsigned     lvl_count[3];
  logic [CfgW-1:0] quantum0_m;
  logic [CfgW-1:0] quantum1_m;

  sched_res_t pending_outcomes[$];
  dir_row_t   dir_rows[$];

  int n_errors, n_requests, n_arrivals, n_ticks, n_drops, n_demotes, n_finishes;
  int n_blocked, n_idle_ticks, n_settings, n_stalls, n_drains, n_checked;
  int burst_left;

  task automatic report(input string msg);
    n_errors++;
    if (n_errors <= 40) $display("mismatch: %s", msg);
  endtask

  function automatic logic [TimeW-1:0] slice_of(input int lvl);
    if (lvl == 0) return quantum0_m;
    if (lvl == 1) return quantum1_m;
    return '0;
  endfunction

  function automatic bit enqueue_job(input int lvl, input logic [IdW-1:0] id,
                                     input logic [TimeW-1:0] burst,
                                     input logic [TimeW-1:0] quant);
    int unsigned tail;
    if (lvl_count[lvl] >= QDepth) return 1'b0;
    tail = (lvl_head[lvl] + lvl_count[lvl]) % QDepth;
    lvl_store[lvl][tail].id    = id;
    lvl_store[lvl][tail].burst = burst;
    lvl_store[lvl][tail].quant = quant;
    lvl_count[lvl]++;
    return 1'b1;
  endfunction

  function automatic void dequeue_job(input int lvl);
    lvl_head[lvl] = (lvl_head[lvl] + 1) % QDepth;
    lvl_count[lvl]--;
  endfunction

  function automatic sched_res_t schedule_step(input sched_req_t r);
    sched_res_t       o;
    int               lvl;
    int unsigned      h;
    logic [TimeW-1:0] b;
    o = '0;
    if (r.req_type == REQ_ARRIVAL) begin
      n_arrivals++;
      // a zero burst still needs one tick
      b = (r.burst_len == '0) ? TimeW'(1) : r.burst_len;
      if (!enqueue_job(0, r.job_id, b, slice_of(0))) begin
        o.arrival_dropped = 1'b1;
        n_drops++;
      end
    end else begin
      n_ticks++;
      lvl = -1;
      for (int k = 2; k >= 0; k--) begin
        if (lvl_count[k] > 0) lvl = k;
      end
      if (lvl < 0) begin
        n_idle_ticks++;
      end else begin
        h = lvl_head[lvl];
        o.run_valid = 1'b1;
        o.run_id    = lvl_store[lvl][h].id;
        o.run_level = LvlW'(lvl);
        if (lvl_store[lvl][h].burst <= 1) begin
          // finishing beats quantum expiry
          o.finished = 1'b1;
          n_finishes++;
          dequeue_job(lvl);
        end else begin
          lvl_store[lvl][h].burst = lvl_store[lvl][h].burst - 1'b1;
          if (lvl < 2) begin
            if (lvl_store[lvl][h].quant <= 1) begin
              if (enqueue_job(lvl + 1, lvl_store[lvl][h].id, lvl_store[lvl][h].burst,
                              slice_of(lvl + 1))) begin
                dequeue_job(lvl);
                o.demoted = 1'b1;
                n_demotes++;
              end else begin
                // next level full: stay put with a reloaded slice
                lvl_store[lvl][h].quant = slice_of(lvl);
                n_blocked++;
              end
            end else begin
              lvl_store[lvl][h].quant = lvl_store[lvl][h].quant - 1'b1;
            end
          end
        end
      end
    end
    return o;
  endfunction

  function automatic dir_row_t mk_row(input logic t, input logic [IdW-1:0] id,
                                      input logic [TimeW-1:0] b, input bit fixed,
                                      input sched_res_t want);
    dir_row_t row;
    row.stim.req_type  = t;
    row.stim.job_id    = id;
    row.stim.burst_len = b;
    row.fixed          = fixed;
    row.want           = want;
    return row;
  endfunction

  task automatic drive_item(input sched_req_t r, input bit fixed, input sched_res_t want);
    sched_res_t p;
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= r.req_type;
    req_ch.job_id    <= r.job_id;
    req_ch.burst_len <= r.burst_len;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    p = schedule_step(r);
    pending_outcomes.push_back(fixed ? want : p);
    n_requests++;
  endtask

  // bursts of back-to-back transactions with random gaps between them
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_outcomes.size() != 0);
    n_drains++;
  endtask

  task automatic write_quanta(input logic [CfgW-1:0] q0, input logic [CfgW-1:0] q1);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_QUANTUM0;
    cfg_data_i <= q0;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_QUANTUM1;
    cfg_data_i <= q1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    quantum0_m = q0;
    quantum1_m = q1;
    n_settings++;
  endtask

  // receiver: checks each result and stalls on its own pattern
  int   ready_hold  = 0;
  logic ready_level = 1'b1;
  always @(posedge clk_i) begin : res_monitor
    sched_res_t got;
    sched_res_t want;
    if (rst_ni && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got.run_valid       = res_ch.run_valid;
      got.run_id          = res_ch.run_id;
      got.run_level       = res_ch.run_level;
      got.finished        = res_ch.finished;
      got.demoted         = res_ch.demoted;
      got.arrival_dropped = res_ch.arrival_dropped;
      if (pending_outcomes.size() == 0) begin
        report($sformatf("result %h with nothing outstanding", got));
      end else begin
        want = pending_outcomes.pop_front();
        if (got.run_valid !== want.run_valid)
          report($sformatf("result %0d run_valid %b, want %b", n_checked,
                           got.run_valid, want.run_valid));
        if (got.run_id !== want.run_id)
          report($sformatf("result %0d run_id %0d, want %0d", n_checked,
                           got.run_id, want.run_id));
        if (got.run_level !== want.run_level)
          report($sformatf("result %0d run_level %0d, want %0d", n_checked,
                           got.run_level, want.run_level));
        if (got.finished !== want.finished)
          report($sformatf("result %0d finished %b, want %b", n_checked,
                           got.finished, want.finished));
        if (got.demoted !== want.demoted)
          report($sformatf("result %0d demoted %b, want %b", n_checked,
                           got.demoted, want.demoted));
        if (got.arrival_dropped !== want.arrival_dropped)
          report($sformatf("result %0d arrival_dropped %b, want %b", n_checked,
                           got.arrival_dropped, want.arrival_dropped));
      end
      n_checked++;
    end
    if (res_ch.valid === 1'b1 && res_ch.ready !== 1'b1) n_stalls++;
    if (ready_hold == 0) begin
      case ($urandom_range(0, 5))
        0: begin
          ready_level = 1'b1;
          ready_hold  = $urandom_range(20, 60);
        end
        1, 2: begin
          ready_level = 1'b0;
          ready_hold  = $urandom_range(1, 8);
        end
        default: begin
          ready_level = 1'b1;
          ready_hold  = $urandom_range(1, 6);
        end
      endcase
    end else begin
      ready_hold--;
    end
    res_ch.ready <= ready_level;
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    sched_req_t  r;
    int          waited;
    int          ph_q0[NPhase];
    int          ph_q1[NPhase];
    int          ph_arr[NPhase];
    int          ph_long[NPhase];
    logic [CfgW-1:0] q0;
    logic [CfgW-1:0] q1;

    // quantum -1 picks a random setting
    ph_q0   = '{1, 0, 1023, 3, -1, 1, 2};
    ph_q1   = '{1, 0, 1023, 7, -1, 1023, 4};
    ph_arr  = '{60, 55, 40, 50, 45, 65, 25};
    ph_long = '{5, 5, 10, 20, 10, 30, 0};

    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= REQ_TICK;
    req_ch.job_id    <= '0;
    req_ch.burst_len <= '0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_QUANTUM0;
    cfg_data_i       <= '0;
    burst_left  = 0;
    for (int l = 0; l < 3; l++) begin
      lvl_head[l]  = 0;
      lvl_count[l] = 0;
    end
    quantum0_m = QUANTUM0_RESET;
    quantum1_m = QUANTUM1_RESET;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, reset quanta 2 and 4
    dir_rows.push_back(mk_row(REQ_TICK, 4'd0, 10'd0, 1'b1, NO_RUN));          // idle tick
    dir_rows.push_back(mk_row(REQ_ARRIVAL, 4'd15, 10'd1023, 1'b1, NO_RUN));
    dir_rows.push_back(mk_row(REQ_ARRIVAL, 4'd0, 10'd0, 1'b1, NO_RUN));       // zero burst
    dir_rows.push_back(mk_row(REQ_TICK, 4'd0, 10'd0, 1'b1,
                              {1'b1, 4'd15, LVL0, 1'b0, 1'b0, 1'b0}));
    dir_rows.push_back(mk_row(REQ_TICK, 4'd0, 10'd0, 1'b1,
                              {1'b1, 4'd15, LVL0, 1'b0, 1'b1, 1'b0}));
    dir_rows.push_back(mk_row(REQ_TICK, 4'd0, 10'd0, 1'b1,
                              {1'b1, 4'd0, LVL0, 1'b1, 1'b0, 1'b0}));
    dir_rows.push_back(mk_row(REQ_ARRIVAL, 4'd5, 10'd2, 1'b0, NO_RUN));
    dir_rows.push_back(mk_row(REQ_TICK, 4'd0, 10'd0, 1'b0, NO_RUN));
    // burst and slice run out together
    dir_rows.push_back(mk_row(REQ_TICK, 4'd0, 10'd0, 1'b1,
                              {1'b1, 4'd5, LVL0, 1'b1, 1'b0, 1'b0}));
    dir_rows.push_back(mk_row(REQ_TICK, 4'd0, 10'd0, 1'b1,
                              {1'b1, 4'd15, LVL1, 1'b0, 1'b0, 1'b0}));
    for (int i = 0; i < QDepth; i++)
      dir_rows.push_back(mk_row(REQ_ARRIVAL, i[IdW-1:0], TimeW'((i * 61 + 7) % 1024),
                                1'b0, NO_RUN));
    // level 0 now full
    dir_rows.push_back(mk_row(REQ_ARRIVAL, 4'd9, 10'd1, 1'b1,
                              {1'b0, 4'd0, LVL0, 1'b0, 1'b0, 1'b1}));

    foreach (dir_rows[i]) begin
      drive_item(dir_rows[i].stim, dir_rows[i].fixed, dir_rows[i].want);
      pace_sender();
    end

    for (int ph = 0; ph < NPhase; ph++) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk_i); while (pending_outcomes.size() != 0);
      repeat (4) @(posedge clk_i);
      q0 = (ph_q0[ph] < 0) ? CfgW'($urandom_range(0, 1023)) : CfgW'(ph_q0[ph]);
      q1 = (ph_q1[ph] < 0) ? CfgW'($urandom_range(0, 1023)) : CfgW'(ph_q1[ph]);
      write_quanta(q0, q1);
      for (int i = 0; i < PhaseItems; i++) begin
        r.req_type = ($urandom_range(0, 99) < ph_arr[ph]) ? REQ_ARRIVAL : REQ_TICK;
        r.job_id   = IdW'($urandom_range(0, 15));
        if ($urandom_range(0, 99) < ph_long[ph]) begin
          r.burst_len = TimeW'($urandom_range(200, 1023));
        end else begin
          case ($urandom_range(0, 9))
            0:       r.burst_len = '0;
            1:       r.burst_len = '1;
            2:       r.burst_len = TimeW'($urandom_range(0, 1023));
            3, 4, 5: r.burst_len = TimeW'($urandom_range(5, 40));
            default: r.burst_len = TimeW'($urandom_range(1, 4));
          endcase
        end
        drive_item(r, 1'b0, NO_RUN);
        if (i == 50 || $urandom_range(0, 199) == 0) drain_results();
        else pace_sender();
      end
    end

    req_ch.valid <= 1'b0;
    waited = 0;
    while (pending_outcomes.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_outcomes.size() != 0)
      report($sformatf("%0d results never arrived", pending_outcomes.size()));
    repeat (6) @(posedge clk_i);

    $display("run covered %0d requests: %0d arrivals (%0d dropped), %0d ticks (%0d idle)",
             n_requests, n_arrivals, n_drops, n_ticks, n_idle_ticks);
    $display("%0d finishes, %0d demotions, %0d blocked moves, %0d quantum settings, %0d stalls",
             n_finishes, n_demotes, n_blocked, n_settings, n_stalls);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
